[rtl/sqe_pkg.sv]
// Shared types and codes for the stack/queue opcode engine.
`timescale 1ns / 1ps

package sqe_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned STATUS_W = 2;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] OP_PUSH = 3'd0;
	localparam logic [MODE_W-1:0] OP_LIST = 3'd1;
	localparam logic [MODE_W-1:0] OP_PEEK = 3'd2;
	localparam logic [MODE_W-1:0] OP_POP  = 3'd3;
	localparam logic [MODE_W-1:0] OP_SWAP = 3'd4;

	// Status codes returned with every result word.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [WORD_W-1:0] value;
	} sqe_in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value_res;
		logic [STATUS_W-1:0]      status;
		logic                     last;
	} sqe_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                rd_next;
		logic                save_tmp;
		logic                push;
		logic                pop;
		logic                wr_top;
		logic                wr_ptr;
		logic                emit;
		logic                emit_data;
		logic                emit_last;
		logic [STATUS_W-1:0] emit_status;
	} sqe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              empty;
		logic              full;
		logic              short_occ;
		logic              list_last;
	} sqe_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LIST,
		S_SWAP_A,
		S_SWAP_B
	} sqe_state_t;

endpackage

[rtl/sqe_ctrl.sv]
// Controller state machine of the stack/queue opcode engine.
`timescale 1ns / 1ps

module sqe_ctrl
	import sqe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  sqe_stat_t stat,
	output sqe_cmd_t  cmd,
	output logic      busy
);

	sqe_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d       = S_IDLE;
				cmd.emit_last = 1'b1;
				unique case (stat.mode)
					OP_PUSH: begin
						cmd.emit = 1'b1;
						if (stat.full) begin
							cmd.emit_status = ST_FULL;
						end else begin
							cmd.push        = 1'b1;
							cmd.emit_status = ST_OK;
						end
					end
					OP_LIST: begin
						// An empty store lists nothing at all.
						if (!stat.empty) begin
							cmd.emit      = 1'b1;
							cmd.emit_data = 1'b1;
							cmd.emit_last = stat.list_last;
							if (!stat.list_last) begin
								cmd.rd_next = 1'b1;
								state_d     = S_LIST;
							end
						end
					end
					OP_PEEK: begin
						cmd.emit = 1'b1;
						if (stat.empty) begin
							cmd.emit_status = ST_EMPTY;
						end else begin
							cmd.emit_data   = 1'b1;
							cmd.emit_status = ST_OK;
						end
					end
					OP_POP: begin
						cmd.emit = 1'b1;
						if (stat.empty) begin
							cmd.emit_status = ST_EMPTY;
						end else begin
							cmd.pop         = 1'b1;
							cmd.emit_status = ST_OK;
						end
					end
					OP_SWAP: begin
						if (stat.short_occ) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_SHORT;
						end else begin
							cmd.rd_next  = 1'b1;
							cmd.save_tmp = 1'b1;
							state_d      = S_SWAP_A;
						end
					end
					default: begin
						cmd.emit_last = 1'b0;
					end
				endcase
			end
			S_LIST: begin
				cmd.emit      = 1'b1;
				cmd.emit_data = 1'b1;
				cmd.emit_last = stat.list_last;
				if (stat.list_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			S_SWAP_A: begin
				cmd.wr_top = 1'b1;
				state_d    = S_SWAP_B;
			end
			S_SWAP_B: begin
				cmd.wr_ptr      = 1'b1;
				cmd.emit        = 1'b1;
				cmd.emit_last   = 1'b1;
				cmd.emit_status = ST_OK;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/sqe_dp.sv]
// Datapath of the stack/queue opcode engine: word memory, ring pointers and result register.
`timescale 1ns / 1ps

module sqe_dp
	import sqe_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sqe_in_t   cmd_in,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  sqe_cmd_t  cmd,
	output sqe_stat_t stat,
	output sqe_out_t  res,
	output logic      res_valid
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned OW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
	localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];

	logic [AW-1:0]       top_q, ptr_q;
	logic [OW-1:0]       occ_q, cnt_q;
	logic                stack_mode_q;
	logic [MODE_W-1:0]   mode_q;
	logic [WORD_W-1:0]   value_q, tmp_q, rd_data_q;
	sqe_out_t            res_q;
	logic                res_valid_q;

	logic [AW-1:0]     top_inc, top_dec, ptr_inc, top_occ, rd_addr, wr_addr;
	logic [AW:0]       occ_sum;
	logic [WORD_W-1:0] wr_data;
	logic              rd_en, wr_en;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		logic [AW:0] s;
		s = {1'b0, p} + (AW+1)'(1);
		if (s >= DEPTH_A) begin
			s = s - DEPTH_A;
		end
		return s[AW-1:0];
	endfunction

	assign top_inc = ring_inc(top_q);
	assign ptr_inc = ring_inc(ptr_q);
	assign top_dec = (top_q == '0) ? LAST_POS : top_q - AW'(1);

	// Occupancy is below the depth whenever a queue push is taken, so one
	// subtract brings the sum back onto the ring.
	assign occ_sum = {1'b0, top_q} + {1'b0, occ_q[AW-1:0]};
	assign top_occ = (occ_sum >= DEPTH_A) ? AW'(occ_sum - DEPTH_A) : occ_sum[AW-1:0];

	assign rd_en   = cmd.load | cmd.rd_next;
	assign rd_addr = cmd.load ? top_q : ptr_inc;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = top_q;
		wr_data = rd_data_q;
		priority if (cmd.push) begin
			wr_en   = 1'b1;
			wr_addr = stack_mode_q ? top_dec : top_occ;
			wr_data = value_q;
		end else if (cmd.wr_top) begin
			wr_en = 1'b1;
		end else if (cmd.wr_ptr) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q;
			wr_data = tmp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= cmd_in.mode;
			value_q <= cmd_in.value;
		end
		if (cmd.save_tmp) begin
			tmp_q <= rd_data_q;
		end
		if (cmd.emit) begin
			res_q.value_res <= cmd.emit_data ? rd_data_q : '0;
			res_q.status    <= cmd.emit_status;
			res_q.last      <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= '0;
			occ_q        <= '0;
			ptr_q        <= '0;
			cnt_q        <= '0;
			stack_mode_q <= 1'b1;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
			if (cfg_we) begin
				stack_mode_q <= cfg_data;
			end
			if (cmd.load) begin
				ptr_q <= top_q;
				cnt_q <= '0;
			end else begin
				if (cmd.rd_next) begin
					ptr_q <= ptr_inc;
				end
				if (cmd.emit) begin
					cnt_q <= cnt_q + OW'(1);
				end
			end
			if (cmd.push) begin
				occ_q <= occ_q + OW'(1);
				if (stack_mode_q) begin
					top_q <= top_dec;
				end
			end else if (cmd.pop) begin
				occ_q <= occ_q - OW'(1);
				top_q <= top_inc;
			end
		end
	end

	assign stat.mode      = mode_q;
	assign stat.empty     = (occ_q == '0);
	assign stat.full      = (occ_q == DEPTH_O);
	assign stat.short_occ = (occ_q < OW'(2));
	assign stat.list_last = ((cnt_q + OW'(1)) == occ_q);

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

[rtl/stack_queue_opcode_engine.sv]
// Top level of the stack/queue opcode engine.
//
//   channel   ports                            handshake
//   command   start, busy, cmd                 taken when start and not busy
//   result    res_valid, res                   one-cycle strobe, no back-pressure
//   config    cfg_valid, cfg_ready, cfg_data   written when valid and ready
//
// Between one accept and the earliest next one, push, peek, pop, every error and the
// unused codes pass through S_EXEC only; swap passes through S_EXEC, S_SWAP_A and
// S_SWAP_B; list emits one word per cycle from S_EXEC and S_LIST, or none on an empty store.
// The word memory has one read and one write port, so swap reads its two words one
// after the other and writes them back one after the other.
// Each result word is registered before it appears on res.
// Reset clears the pointers and occupancy and sets stack mode; memory contents are not reset.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps

module stack_queue_opcode_engine
	import sqe_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sqe_in_t  cmd,
	output logic     res_valid,
	output sqe_out_t res,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	sqe_cmd_t  ctl_cmd;
	sqe_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	sqe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (ctl_cmd),
		.busy   (busy)
	);

	sqe_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (ctl_cmd),
		.stat      (dp_stat),
		.res       (res),
		.res_valid (res_valid)
	);

endmodule
